>>> sv/oid_pkg.sv
// ----------------------------------------------------------------------------
// OID decoder package
// Shared widths, status codes and result types of the OID sub-identifier
// decoder.
// ----------------------------------------------------------------------------
package oid_pkg;

  localparam int OctetW   = 8;
  localparam int ArcW     = 28;
  localparam int StatusW  = 2;
  // First sub-identifier split point between the top-level arcs.
  localparam int ArcSplit = 40;

  typedef enum logic [StatusW-1:0] {
    StatusOk       = 2'd0,
    StatusBadSubid = 2'd1,
    StatusTooFew   = 2'd2
  } status_e;

  typedef struct packed {
    logic [ArcW-1:0] arc;
    logic            final_res;
    status_e         status;
  } result_t;

  // Results produced by one input byte: num is 0, 1 or 2.
  typedef struct packed {
    logic [1:0] num;
    result_t    r0;
    result_t    r1;
  } pair_t;

endpackage

>>> sv/oid_in_if.sv
// ----------------------------------------------------------------------------
// OID input channel
// Valid/ready channel carrying one content byte and its last flag.
// ----------------------------------------------------------------------------
interface oid_in_if;
  logic                        valid;
  logic                        ready;
  logic [oid_pkg::OctetW-1:0]  octet;
  logic                        last;

  modport source (output valid, output octet, output last, input ready);
  modport sink   (input valid, input octet, input last, output ready);
endinterface

>>> sv/oid_out_if.sv
// ----------------------------------------------------------------------------
// OID result channel
// Valid/ready channel carrying one decoded arc with final flag and status.
// ----------------------------------------------------------------------------
interface oid_out_if;
  logic                         valid;
  logic                         ready;
  logic [oid_pkg::ArcW-1:0]     arc;
  logic                         final_res;
  logic [oid_pkg::StatusW-1:0]  status;

  modport source (output valid, output arc, output final_res, output status, input ready);
  modport sink   (input valid, input arc, input final_res, input status, output ready);
endinterface

>>> sv/oid_core.sv
// ----------------------------------------------------------------------------
// OID decoder core
// Input register and per-byte decode: base-128 gathering, first
// sub-identifier split and error tracking.
// ----------------------------------------------------------------------------
module oid_core #(
  parameter int MaxSubidBytes = 4
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [oid_pkg::OctetW-1:0] octet_i,
  input  logic                       last_i,
  input  logic                       buf_ready_i,
  output oid_pkg::pair_t             push_o
);
  import oid_pkg::*;

  localparam int CntW = $clog2(MaxSubidBytes + 1);
  localparam logic [CntW-1:0] CntMax = CntW'(MaxSubidBytes);
  localparam logic [ArcW-1:0] Split1 = ArcW'(ArcSplit);
  localparam logic [ArcW-1:0] Split2 = ArcW'(2 * ArcSplit);

  logic              in_valid_q;
  logic [OctetW-1:0] octet_q;
  logic              last_q;
  logic              fire;

  logic [ArcW-1:0]   acc_q, acc_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic              first_q, first_d;
  status_e           err_q, err_d;
  logic [ArcW-1:0]   shifted;
  pair_t             push;

  assign fire       = in_valid_q && buf_ready_i;
  assign in_ready_o = !in_valid_q || buf_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_valid_i && in_ready_o) begin
      in_valid_q <= 1'b1;
    end else if (fire) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      octet_q <= octet_i;
      last_q  <= last_i;
    end
  end

  assign shifted = {acc_q[ArcW-8:0], octet_q[6:0]};

  always_comb begin
    acc_d   = acc_q;
    cnt_d   = cnt_q;
    first_d = first_q;
    err_d   = err_q;
    push    = '0;
    if (err_q == StatusOk) begin
      if (octet_q[7]) begin
        acc_d = shifted;
        if (cnt_q < CntMax) begin
          cnt_d = cnt_q + CntW'(1);
        end
        // A continuation byte on the last byte leaves the sub-identifier open.
        if (cnt_d == CntMax || last_q) begin
          err_d = StatusBadSubid;
        end
      end else begin
        acc_d = '0;
        cnt_d = '0;
        if (!first_q) begin
          first_d = 1'b1;
          if (last_q) begin
            err_d = StatusTooFew;
          end else begin
            push.num = 2'd2;
            if (shifted < Split1) begin
              push.r0.arc = ArcW'(0);
              push.r1.arc = shifted;
            end else if (shifted < Split2) begin
              push.r0.arc = ArcW'(1);
              push.r1.arc = shifted - Split1;
            end else begin
              push.r0.arc = ArcW'(2);
              push.r1.arc = shifted - Split2;
            end
          end
        end else begin
          push.num          = 2'd1;
          push.r0.arc       = shifted;
          push.r0.final_res = last_q;
        end
      end
    end
    if (last_q) begin
      if (err_d != StatusOk) begin
        push.num          = 2'd1;
        push.r0.arc       = '0;
        push.r0.final_res = 1'b1;
        push.r0.status    = err_d;
      end
      acc_d   = '0;
      cnt_d   = '0;
      first_d = 1'b0;
      err_d   = StatusOk;
    end
    if (!fire) begin
      push.num = 2'd0;
    end
  end

  assign push_o = push;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q   <= '0;
      cnt_q   <= '0;
      first_q <= 1'b0;
      err_q   <= StatusOk;
    end else if (fire) begin
      acc_q   <= acc_d;
      cnt_q   <= cnt_d;
      first_q <= first_d;
      err_q   <= err_d;
    end
  end

  // The closing byte returns every piece of decode state to its reset value.
  a_last_clears : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && last_q) |=> (acc_q == '0 && cnt_q == '0 && !first_q && err_q == StatusOk))
    else $error("decode state not cleared after last byte");

  // An error result is always final and carries a zero arc.
  a_err_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push.num != 2'd0 && push.r0.status != StatusOk) |->
      (push.r0.final_res && push.r0.arc == '0))
    else $error("error result malformed");

  // The two arcs of the first sub-identifier are never final.
  a_pair_not_final : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push.num == 2'd2) |-> (!push.r0.final_res && !push.r1.final_res && push.r0.arc <= 2))
    else $error("first sub-identifier split malformed");

endmodule

>>> sv/oid_rbuf.sv
// ----------------------------------------------------------------------------
// OID result buffer
// Three-entry result queue that takes up to two results per byte and hands
// them out one per request.
// ----------------------------------------------------------------------------
module oid_rbuf (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  oid_pkg::pair_t   push_i,
  output logic             ready_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output oid_pkg::result_t head_o
);
  import oid_pkg::*;

  localparam int Depth = 3;

  result_t    slot_q [Depth];
  result_t    slot_d [Depth];
  result_t    sh     [Depth];
  logic [1:0] cnt_q, cnt_d;
  logic [1:0] base;
  logic       pop;

  assign pop         = (cnt_q != 2'd0) && out_ready_i;
  assign ready_o     = !cnt_q[1];
  assign out_valid_o = cnt_q != 2'd0;
  assign head_o      = slot_q[0];
  assign base        = cnt_q - {1'b0, pop};
  assign cnt_d       = base + push_i.num;

  always_comb begin
    for (int i = 0; i < Depth; i++) begin
      sh[i] = slot_q[i];
    end
    if (pop) begin
      for (int i = 0; i < Depth - 1; i++) begin
        sh[i] = slot_q[i+1];
      end
    end
    for (int i = 0; i < Depth; i++) begin
      slot_d[i] = sh[i];
      if (push_i.num != 2'd0 && base == 2'(i)) begin
        slot_d[i] = push_i.r0;
      end
      if (push_i.num == 2'd2 && (base + 2'd1) == 2'(i)) begin
        slot_d[i] = push_i.r1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < Depth; i++) begin
      slot_q[i] <= slot_d[i];
    end
  end

  // The decoder only writes while there is room for a full pair.
  a_push_room : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i.num != 2'd0) |-> ready_o)
    else $error("result pushed into a full buffer");

  // Occupancy moves by the pushed count less one per handed-out result.
  a_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> (cnt_q == $past(cnt_q) + $past(push_i.num) - {1'b0, $past(pop)}))
    else $error("result count out of step");

endmodule

>>> sv/oid_subidentifier_decoder.sv
// ----------------------------------------------------------------------------
// OID sub-identifier decoder
// Decodes DER object identifier content bytes into arcs with a final status.
// ----------------------------------------------------------------------------
// One content byte is taken per cycle while the result buffer has room. A byte
// is registered on entry and decoded into a three-entry result buffer once that
// buffer has room for two results. Each byte gives zero or one result, except
// the byte that ends the first sub-identifier, which, unless it is the last
// byte, gives its two arcs; those are handed out one at a time, so the byte
// after it may wait for room. The result with final_res set closes the
// identifier; a nonzero status there means the arcs already delivered for
// that identifier are to be dropped. MaxSubidBytes (2 to 9) bounds the
// bytes of one sub-identifier; the arc keeps the low 28 bits.
module oid_subidentifier_decoder #(
  parameter int MaxSubidBytes = 4
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  oid_in_if.sink    in_i,
  oid_out_if.source out_o
);
  import oid_pkg::*;

  pair_t   push;
  logic    buf_ready;
  result_t head;

  oid_core #(
    .MaxSubidBytes(MaxSubidBytes)
  ) u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .octet_i    (in_i.octet),
    .last_i     (in_i.last),
    .buf_ready_i(buf_ready),
    .push_o     (push)
  );

  oid_rbuf u_rbuf (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .ready_o    (buf_ready),
    .out_valid_o(out_o.valid),
    .out_ready_i(out_o.ready),
    .head_o     (head)
  );

  assign out_o.arc       = head.arc;
  assign out_o.final_res = head.final_res;
  assign out_o.status    = head.status;

endmodule

>>> tb/sv/oid_subidentifier_decoder_test.sv
// ----------------------------------------------------------------------------
// OID sub-identifier decoder test
// Drives DER object identifier content bytes into the decoder and checks
// every arc, final flag and status against a cycle-free model of the
// decoding rules. A short directed table comes first, followed by random
// identifiers that are mostly well formed. Both channels idle at random,
// and one phase holds the result side off long enough to stall the input.
// ----------------------------------------------------------------------------
module oid_subidentifier_decoder_test;
  import oid_pkg::*;

  localparam int MaxSubid    = 4;
  localparam int NumItems    = 1750;
  localparam int NumDirRows  = 24;
  localparam int SettleCycles = 12;
  localparam int CycleLimit  = 600000;
  localparam logic [ArcW-1:0] ArcMax = {ArcW{1'b1}};

  typedef struct {
    logic [OctetW-1:0] octet;
    logic              last;
    bit                typed;
    pair_t             want;
  } dir_row_t;

  logic clk_i;
  logic rst_ni;

  oid_in_if  in_ch ();
  oid_out_if out_ch ();

  oid_subidentifier_decoder #(
    .MaxSubidBytes(MaxSubid)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_ch),
    .out_o (out_ch)
  );

  // Decoder state as the model sees it.
  logic [ArcW-1:0] acc_r;
  int unsigned     cont_cnt;
  logic [1:0]      seen_cnt;
  status_e         err_st;

  result_t         expected_q[$];
  logic [OctetW-1:0] ident_bytes[$];
  dir_row_t        dir_rows[NumDirRows];

  int   items_sent;
  int   err_cnt;
  int   cycle_cnt;
  bit   src_idle;
  bit   snk_idle;
  int   sink_wait;
  int   sink_hold_req;
  int   sink_hold_left;

  function automatic pair_t decode_octet(input logic [OctetW-1:0] oct, input logic lst);
    pair_t           p;
    logic [ArcW-1:0] v;
    p = '0;
    if (err_st == StatusOk) begin
      acc_r = {acc_r[ArcW-8:0], oct[6:0]};
      if (oct[7]) begin
        if (cont_cnt < MaxSubid) cont_cnt++;
        if (cont_cnt >= MaxSubid || lst) err_st = StatusBadSubid;
      end else begin
        v        = acc_r;
        acc_r    = '0;
        cont_cnt = 0;
        if (seen_cnt == 2'd0) begin
          seen_cnt = 2'd1;
          if (lst) begin
            err_st = StatusTooFew;
          end else begin
            p.num = 2'd2;
            if (v < ArcSplit) begin
              p.r0.arc = '0;
              p.r1.arc = v;
            end else if (v < 2 * ArcSplit) begin
              p.r0.arc = ArcW'(1);
              p.r1.arc = v - ArcW'(ArcSplit);
            end else begin
              p.r0.arc = ArcW'(2);
              p.r1.arc = v - ArcW'(2 * ArcSplit);
            end
          end
        end else begin
          seen_cnt       = 2'd2;
          p.num          = 2'd1;
          p.r0.arc       = v;
          p.r0.final_res = lst;
        end
      end
    end
    if (lst) begin
      if (err_st != StatusOk) begin
        p.num          = 2'd1;
        p.r0.arc       = '0;
        p.r0.final_res = 1'b1;
        p.r0.status    = err_st;
      end
      acc_r    = '0;
      cont_cnt = 0;
      seen_cnt = 2'd0;
      err_st   = StatusOk;
    end
    return p;
  endfunction

  function automatic pair_t arcs2(input logic [ArcW-1:0] a0, input logic [ArcW-1:0] a1);
    pair_t p;
    p        = '0;
    p.num    = 2'd2;
    p.r0.arc = a0;
    p.r1.arc = a1;
    return p;
  endfunction

  function automatic pair_t res1(input logic [ArcW-1:0] a, input logic fin, input status_e st);
    pair_t p;
    p              = '0;
    p.num          = 2'd1;
    p.r0.arc       = a;
    p.r0.final_res = fin;
    p.r0.status    = st;
    return p;
  endfunction

  function automatic logic [6:0] draw_payload();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return 7'h00;
    if (r < 20) return 7'h7f;
    return 7'($urandom_range(0, 127));
  endfunction

  // Appends one sub-identifier of nb bytes: nb-1 continuation bytes and a terminator.
  function automatic void push_subid(input int nb);
    for (int i = 0; i < nb - 1; i++) ident_bytes.push_back({1'b1, draw_payload()});
    ident_bytes.push_back({1'b0, draw_payload()});
  endfunction

  function automatic int draw_subid_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 1;
    if (r < 85) return 2;
    if (r < 95) return 3;
    return MaxSubid;
  endfunction

  task automatic send_octet(input logic [OctetW-1:0] oct, input logic lst, input bit typed,
                            input pair_t want);
    int    gap;
    pair_t got;
    gap = src_idle ? $urandom_range(0, 15) : 0;
    if (gap > 0) begin
      in_ch.valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_ch.octet = oct;
    in_ch.last  = lst;
    in_ch.valid = 1'b1;
    do @(posedge clk_i); while (!in_ch.ready);
    got = decode_octet(oct, lst);
    if (typed) got = want;
    if (got.num > 0) expected_q.push_back(got.r0);
    if (got.num > 1) expected_q.push_back(got.r1);
    items_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_identifier();
    int kind;
    int n;
    kind = $urandom_range(0, 99);
    ident_bytes.delete();
    if (kind < 80) begin
      n = $urandom_range(2, 7);
      repeat (n) push_subid(draw_subid_len());
    end else if (kind < 88) begin
      // Truncated: the last byte still has its continuation bit set.
      n = $urandom_range(0, 3);
      repeat (n) push_subid(draw_subid_len());
      repeat ($urandom_range(0, MaxSubid - 2)) ident_bytes.push_back({1'b1, draw_payload()});
      ident_bytes.push_back({1'b1, draw_payload()});
    end else if (kind < 94) begin
      n = $urandom_range(0, 2);
      repeat (n) push_subid(draw_subid_len());
      push_subid(MaxSubid + 1 + $urandom_range(0, 3));
      repeat ($urandom_range(0, 2)) push_subid(draw_subid_len());
    end else if (kind < 97) begin
      push_subid(draw_subid_len());
    end else begin
      repeat ($urandom_range(1, 10)) ident_bytes.push_back(8'($urandom_range(0, 255)));
    end
    foreach (ident_bytes[i]) send_octet(ident_bytes[i], i == ident_bytes.size() - 1, 1'b0, '0);
  endtask

  task automatic drain_results();
    in_ch.valid = 1'b0;
    while (expected_q.size() != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < CycleLimit) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("oid_subidentifier_decoder_test: FAIL");
    $finish;
  end

  initial begin
    out_ch.ready   = 1'b0;
    sink_wait      = 0;
    sink_hold_req  = 0;
    sink_hold_left = 0;
  end

  // Result side: a long hold when asked for, otherwise the per-result wait.
  always @(negedge clk_i) begin
    if (sink_hold_req > 0) begin
      sink_hold_left = sink_hold_req;
      sink_hold_req  = 0;
    end
    if (!rst_ni) begin
      out_ch.ready = 1'b0;
    end else if (sink_hold_left > 0) begin
      out_ch.ready = 1'b0;
      sink_hold_left--;
    end else if (sink_wait > 0) begin
      out_ch.ready = 1'b0;
      sink_wait--;
    end else begin
      out_ch.ready = 1'b1;
    end
  end

  always @(posedge clk_i) begin
    result_t exp_res;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      sink_wait = snk_idle ? $urandom_range(0, 15) : 0;
      if (expected_q.size() == 0) begin
        $error("unexpected result: arc %0d final_res %0d status %0d",
               out_ch.arc, out_ch.final_res, out_ch.status);
        err_cnt++;
      end else begin
        exp_res = expected_q.pop_front();
        if (out_ch.arc !== exp_res.arc) begin
          $error("arc: expected %0d, got %0d", exp_res.arc, out_ch.arc);
          err_cnt++;
        end
        if (out_ch.final_res !== exp_res.final_res) begin
          $error("final_res: expected %0d, got %0d", exp_res.final_res, out_ch.final_res);
          err_cnt++;
        end
        if (out_ch.status !== exp_res.status) begin
          $error("status: expected %0d, got %0d", exp_res.status, out_ch.status);
          err_cnt++;
        end
      end
    end
  end

  initial begin
    int phase_end;
    rst_ni      = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.octet = '0;
    in_ch.last  = 1'b0;
    items_sent  = 0;
    err_cnt     = 0;
    src_idle    = 1'b1;
    snk_idle    = 1'b1;
    acc_r       = '0;
    cont_cnt    = 0;
    seen_cnt    = 2'd0;
    err_st      = StatusOk;

    dir_rows = '{
      '{8'h27, 1'b0, 1'b1, arcs2(0, 39)},
      '{8'h06, 1'b0, 1'b0, '0},
      '{8'h01, 1'b1, 1'b0, '0},
      '{8'h00, 1'b0, 1'b1, arcs2(0, 0)},
      '{8'h7f, 1'b1, 1'b0, '0},
      // Largest first sub-identifier, then the largest later one.
      '{8'hff, 1'b0, 1'b0, '0},
      '{8'hff, 1'b0, 1'b0, '0},
      '{8'hff, 1'b0, 1'b0, '0},
      '{8'h7f, 1'b0, 1'b1, arcs2(2, ArcMax - ArcW'(80))},
      '{8'hff, 1'b0, 1'b0, '0},
      '{8'hff, 1'b0, 1'b0, '0},
      '{8'hff, 1'b0, 1'b0, '0},
      '{8'h7f, 1'b1, 1'b1, res1(ArcMax, 1'b1, StatusOk)},
      '{8'h28, 1'b1, 1'b1, res1(0, 1'b1, StatusTooFew)},
      '{8'h80, 1'b1, 1'b1, res1(0, 1'b1, StatusBadSubid)},
      '{8'h4f, 1'b0, 1'b1, arcs2(1, 39)},
      '{8'h81, 1'b1, 1'b1, res1(0, 1'b1, StatusBadSubid)},
      // One continuation byte too many, then bytes that are absorbed.
      '{8'h50, 1'b0, 1'b1, arcs2(2, 0)},
      '{8'h81, 1'b0, 1'b0, '0},
      '{8'h82, 1'b0, 1'b0, '0},
      '{8'h83, 1'b0, 1'b0, '0},
      '{8'h84, 1'b0, 1'b1, '0},
      '{8'h05, 1'b0, 1'b1, '0},
      '{8'h06, 1'b1, 1'b1, res1(0, 1'b1, StatusBadSubid)}
    };

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (dir_rows[i])
      send_octet(dir_rows[i].octet, dir_rows[i].last, dir_rows[i].typed, dir_rows[i].want);
    drain_results();

    // Hold the result side off while requests keep coming back to back.
    src_idle      = 1'b0;
    snk_idle      = 1'b0;
    sink_hold_req = 300;
    phase_end     = items_sent + 60;
    while (items_sent < phase_end) send_identifier();
    drain_results();

    while (items_sent < NumItems + NumDirRows) begin
      src_idle  = 1'($urandom_range(0, 1));
      snk_idle  = 1'($urandom_range(0, 1));
      phase_end = items_sent + $urandom_range(100, 250);
      while (items_sent < phase_end) send_identifier();
      if ($urandom_range(0, 1)) drain_results();
    end
    drain_results();

    if (err_cnt == 0) begin
      $display("oid_subidentifier_decoder_test: PASS");
    end else begin
      $display("oid_subidentifier_decoder_test: FAIL");
    end
    $finish;
  end

endmodule
